FILE: rtl/core/tsti_pkg.sv
// Package: segment and ROM constants for the tangent table interpolator.
`default_nettype none
package tsti_pkg;

  localparam int unsigned NumSegs  = 6;
  localparam int unsigned NumRows  = 20;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned FoldW    = 15;
  localparam int unsigned SegW     = 3;
  localparam int unsigned RowW     = 5;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned MultW    = 12;
  localparam int unsigned ValueW   = 31;
  localparam int unsigned SlopeW   = 29;
  localparam int unsigned ProdW    = MultW + SlopeW;
  localparam int unsigned SumW     = 33;
  localparam int unsigned TanW     = 32;

  typedef logic [SegW-1:0] seg_t;

  localparam seg_t SEG_0 = 3'd0;
  localparam seg_t SEG_1 = 3'd1;
  localparam seg_t SEG_2 = 3'd2;
  localparam seg_t SEG_3 = 3'd3;
  localparam seg_t SEG_4 = 3'd4;
  localparam seg_t SEG_5 = 3'd5;

  localparam logic [RowW-1:0] LAST_ROW = 5'd19;
  localparam logic [ValueW-1:0] TAN_MAX = 31'h7FFF_FFFF;

  localparam logic [FoldW-1:0] SEG_BASE [NumSegs] = '{
    15'h0000, 15'h3000, 15'h3C00, 15'h3F00, 15'h3FC0, 15'h3FF0
  };
  localparam logic [ShiftW-1:0] SEG_SHIFT [NumSegs] = '{
    4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2
  };
  localparam logic [RowW-1:0] SEG_ROW0 [NumSegs] = '{
    5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15
  };

  localparam logic [ValueW-1:0] TAN_VALUE [NumRows] = '{
    31'd0,        31'd27146,    31'd65536,
    31'd158218,   31'd216043,   31'd329472,
    31'd665398,   31'd888450,   31'd1334016,
    31'd2669640,  31'd3559834,  31'd5340086,
    31'd10680574, 31'd14240842, 31'd21361348,
    31'd42722797, 31'd56963748, 31'd85445643, 31'd170891311, 31'd2147483647
  };

  localparam logic [SlopeW-1:0] TAN_SLOPE [NumRows] = '{
    29'd27145,    29'd38390,    29'd92681,
    29'd57825,    29'd113428,   29'd335926,
    29'd223051,   29'd445566,   29'd1335624,
    29'd890193,   29'd1780251,  29'd5340487,
    29'd3560269,  29'd7120505,  29'd21361448,
    29'd14240951, 29'd28481894, 29'd85445668, 29'd365979601, 29'd0
  };

endpackage
`default_nettype wire

FILE: rtl/core/tangent_segmented_table_interpolator.sv
// Tangent of a binary angle: four-stage segmented table interpolator.
// One item per cycle while the output is not stalled; stages are fold/segment, ROM + multiply,
// shift + add, negate + saturate into the output register.
// A stall on the output holds each occupied stage that has no empty stage after it; bubbles are filled.
// Reset (rst_ni low, asynchronous) empties the pipeline; no payload reset.
`default_nettype none
module tangent_segmented_table_interpolator
  import tsti_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [AngleW-1:0] angle_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [TanW-1:0] tangent_o
);

  localparam int unsigned NumStages = 4;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[3] = !valid_q[3] || !out_stall_i;
    adv[2] = !valid_q[2] || adv[3];
    adv[1] = !valid_q[1] || adv[2];
    adv[0] = !valid_q[0] || adv[1];
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      if (adv[1]) valid_q[1] <= valid_q[0];
      if (adv[2]) valid_q[2] <= valid_q[1];
      if (adv[3]) valid_q[3] <= valid_q[2];
    end
  end

  // stage 1: fold into first quarter, pick segment, row and low bits
  logic [FoldW-1:0]  half_a;
  logic [FoldW-1:0]  fold_a;
  logic              neg_d;
  seg_t              seg;
  logic [FoldW-1:0]  offs;
  logic [RowW-1:0]   row_sum;
  logic [RowW-1:0]   row_d;
  logic [FoldW-1:0]  mask;
  logic [MultW-1:0]  mult_d;
  logic [ShiftW-1:0] shift_d;

  always_comb begin
    half_a = angle_i[FoldW-1:0];
    neg_d  = half_a[FoldW-1];
    fold_a = neg_d ? FoldW'(16'd32768 - {1'b0, half_a}) : half_a;
    priority if (fold_a >= SEG_BASE[SEG_5]) seg = SEG_5;
    else if (fold_a >= SEG_BASE[SEG_4])     seg = SEG_4;
    else if (fold_a >= SEG_BASE[SEG_3])     seg = SEG_3;
    else if (fold_a >= SEG_BASE[SEG_2])     seg = SEG_2;
    else if (fold_a >= SEG_BASE[SEG_1])     seg = SEG_1;
    else                                    seg = SEG_0;
    shift_d = SEG_SHIFT[seg];
    offs    = fold_a - SEG_BASE[seg];
    row_sum = SEG_ROW0[seg] + RowW'(offs >> shift_d);
    row_d   = (row_sum > LAST_ROW) ? LAST_ROW : row_sum;
    mask    = (FoldW'(1) << shift_d) - FoldW'(1);
    mult_d  = MultW'(fold_a & mask);
  end

  logic              s1_neg_q;
  logic [RowW-1:0]   s1_row_q;
  logic [MultW-1:0]  s1_mult_q;
  logic [ShiftW-1:0] s1_shift_q;

  // stage 2: ROM read and multiply
  logic [ProdW-1:0]  prod_d;
  assign prod_d = ProdW'(s1_mult_q) * ProdW'(TAN_SLOPE[s1_row_q]);

  logic              s2_neg_q;
  logic [ShiftW-1:0] s2_shift_q;
  logic [ValueW-1:0] s2_value_q;
  logic [ProdW-1:0]  s2_prod_q;

  // stage 3: scale and add base
  logic [ProdW-1:0]  scaled;
  logic [SumW-1:0]   sum_d;
  assign scaled = s2_prod_q >> s2_shift_q;
  assign sum_d  = SumW'(s2_value_q) + SumW'(scaled[TanW-1:0]);

  logic              s3_neg_q;
  logic [SumW-1:0]   s3_sum_q;

  // stage 4: saturate and negate
  logic [ValueW-1:0]     mag;
  logic signed [TanW-1:0] tangent_d;
  always_comb begin
    mag       = (s3_sum_q > SumW'(TAN_MAX)) ? TAN_MAX : s3_sum_q[ValueW-1:0];
    tangent_d = s3_neg_q ? -TanW'(mag) : TanW'(mag);
  end

  logic signed [TanW-1:0] tangent_q;
  assign tangent_o = tangent_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_neg_q   <= neg_d;
      s1_row_q   <= row_d;
      s1_mult_q  <= mult_d;
      s1_shift_q <= shift_d;
    end
    if (adv[1]) begin
      s2_neg_q   <= s1_neg_q;
      s2_shift_q <= s1_shift_q;
      s2_value_q <= TAN_VALUE[s1_row_q];
      s2_prod_q  <= prod_d;
    end
    if (adv[2]) begin
      s3_neg_q <= s2_neg_q;
      s3_sum_q <= sum_d;
    end
    if (adv[3]) begin
      tangent_q <= tangent_d;
    end
  end

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> s1_row_q <= LAST_ROW)
    else $error("ROM row beyond table");

  a_no_min_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tangent_o != 32'sh8000_0000)
    else $error("tangent outside symmetric range");

  a_hold_stage3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[2] && !adv[3]) |=> (valid_q[2] && $stable(s3_sum_q) && $stable(s3_neg_q)))
    else $error("blocked item lost in stage three");

  a_mult_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> (FoldW'(s1_mult_q) >> s1_shift_q) == '0)
    else $error("low bits wider than segment step");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for the tangent table interpolator: directed and random angles, random idling, per-item checks.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit  = 2000;
  localparam int TailCycles = 24;
  localparam int RandomItems = 1650;

  typedef struct packed {
    logic [15:0] angle;
    logic        drain;
  } pending_angle_t;

  // segment floors, shift widths and first rows, coarsest segment first
  localparam int unsigned SEG_FLOOR [6] = '{'h0000, 'h3000, 'h3C00, 'h3F00, 'h3FC0, 'h3FF0};
  localparam int unsigned SEG_BITS  [6] = '{12, 10, 8, 6, 4, 2};
  localparam int unsigned SEG_FIRST [6] = '{0, 3, 6, 9, 12, 15};

  localparam longint ROW_VALUE [20] = '{
    0, 27146, 65536,
    158218, 216043, 329472,
    665398, 888450, 1334016,
    2669640, 3559834, 5340086,
    10680574, 14240842, 21361348,
    42722797, 56963748, 85445643, 170891311, 2147483647
  };
  localparam longint ROW_SLOPE [20] = '{
    27145, 38390, 92681,
    57825, 113428, 335926,
    223051, 445566, 1335624,
    890193, 1780251, 5340487,
    3560269, 7120505, 21361448,
    14240951, 28481894, 85445668, 365979601, 0
  };

  logic                              clk_i = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [tsti_pkg::AngleW-1:0]       angle = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [tsti_pkg::TanW-1:0]  tangent;

  pending_angle_t            pending_angles[$];
  logic signed [31:0]        expected_tangents[$];
  int                        mismatches = 0;
  int                        send_wait = 0;
  int                        send_calm = 0;
  int                        recv_wait = 0;
  int                        recv_calm = 0;
  int                        idle_cycles = 0;

  tangent_segmented_table_interpolator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .angle_i     (angle),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .tangent_o   (tangent)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] tangent_of(logic [15:0] ang);
    logic [14:0]  a;
    logic         negate;
    int unsigned  seg;
    int unsigned  row;
    longint       mult;
    longint       sum;
    // adding half a turn only flips bit 15
    a = ang[14:0];
    negate = a > 15'd16383;
    if (negate) a = 15'(16'd32768 - {1'b0, a});
    seg = 0;
    for (int s = 1; s < 6; s++)
      if (a >= SEG_FLOOR[s]) seg = unsigned'(s);
    row = SEG_FIRST[seg] + ((a - SEG_FLOOR[seg]) >> SEG_BITS[seg]);
    if (row > 19) row = 19;
    mult = longint'(a) & ((longint'(1) << SEG_BITS[seg]) - 1);
    sum = ROW_VALUE[row] + ((mult * ROW_SLOPE[row]) >>> SEG_BITS[seg]);
    if (negate) sum = -sum;
    if (sum > 2147483647) sum = 2147483647;
    if (sum < -2147483647) sum = -2147483647;
    return sum[31:0];
  endfunction

  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  // folded angle 0..16384 placed in a random quarter
  function automatic logic [15:0] place_in_quarter(int folded);
    logic [16:0] ang;
    case ($urandom_range(0, 3))
      0: ang = 17'(folded);
      1: ang = 17'(32768 - folded);
      2: ang = 17'(32768 + folded);
      default: ang = 17'(65536 - folded);
    endcase
    return ang[15:0];
  endfunction

  function automatic logic [15:0] random_angle();
    int folded;
    case ($urandom_range(0, 3))
      2: folded = 16384 - int'($urandom_range(0, 300));
      3: begin
        folded = int'(SEG_FLOOR[$urandom_range(0, 5)]) + int'($urandom_range(0, 8)) - 4;
        if (folded < 0) folded = 0;
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
    return place_in_quarter(folded);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin : drive_angles
    logic send_now;
    if (rst_n) begin
      send_now = in_valid;
      if (in_valid && !in_stall) begin
        expected_tangents.push_back(tangent_of(angle));
        send_now = 1'b0;
      end
      if (!send_now) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (pending_angles.size() != 0 &&
                     !(pending_angles[0].drain && expected_tangents.size() != 0)) begin
          angle <= pending_angles[0].angle;
          pending_angles.pop_front();
          send_now = 1'b1;
          send_wait = draw_idle(send_calm);
        end
      end
      in_valid <= send_now;
    end
  end

  always @(posedge clk_i) begin : check_tangents
    logic signed [31:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_tangents.size() == 0) begin
          report_mismatch($sformatf("tangent %0d with no angle pending", tangent));
        end else begin
          want = expected_tangents.pop_front();
          if (tangent !== want)
            report_mismatch($sformatf("tangent %0d, want %0d", tangent, want));
        end
        recv_wait = draw_idle(recv_calm);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] directed [24] = '{
      16'h0000, 16'h0001, 16'h2FFF, 16'h3000, 16'h3BFF, 16'h3C00, 16'h3EFF, 16'h3F00,
      16'h3FBF, 16'h3FC0, 16'h3FEF, 16'h3FF0, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF,
      16'h8000, 16'h8001, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF, 16'h5555, 16'hAAAA
    };
    foreach (directed[i]) pending_angles.push_back('{angle: directed[i], drain: 1'b0});
    for (int i = 0; i < RandomItems; i++)
      pending_angles.push_back('{angle: random_angle(),
                                 drain: (i == 0) || (i % 400 == 399) ||
                                        ($urandom_range(0, 199) == 0)});
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    while (pending_angles.size() != 0 || in_valid || expected_tangents.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_tangents.size() != 0)
      report_mismatch($sformatf("%0d tangents never arrived", expected_tangents.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
